### design/gso_pkg.sv
// ----------------------------------------------------------------------------
// gso_pkg
// shared types, register indexes and saturating fixed-point helpers for the
// gram-schmidt orthonormalizer
// ----------------------------------------------------------------------------
package gso_pkg;

    localparam logic [1:0] CFG_ROWS  = 2'd0;
    localparam logic [1:0] CFG_COLS  = 2'd1;
    localparam logic [1:0] CFG_START = 2'd2;

    typedef struct packed {
        logic               sat;
        logic signed [63:0] val;
    } t_sat64;

    typedef struct packed {
        logic               sat;
        logic signed [31:0] val;
    } t_sat32;

    function automatic t_sat64 sat_add64(logic signed [63:0] a, logic signed [63:0] b);
        t_sat64      res;
        logic [63:0] sum;
        sum = a + b;
        res.sat = 1'b0;
        res.val = sum;
        if (a[63] == b[63] && sum[63] != a[63]) begin
            res.sat = 1'b1;
            res.val = a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end
        return res;
    endfunction

    // q32.32 to q16.16, half away from zero, clipped to 32 bits
    function automatic t_sat32 round_q16(logic signed [63:0] x);
        t_sat32      res;
        logic [63:0] mag;
        logic [63:0] t;
        mag = x[63] ? (64'd0 - x) : x;
        t   = (mag + 64'd32768) >> 16;
        res.sat = 1'b0;
        if (x[63]) begin
            if (t > 64'h8000_0000) begin
                res.sat = 1'b1;
                res.val = 32'sh8000_0000;
            end else begin
                res.val = 32'(64'd0 - t);
            end
        end else begin
            if (t > 64'h7fff_ffff) begin
                res.sat = 1'b1;
                res.val = 32'sh7fff_ffff;
            end else begin
                res.val = t[31:0];
            end
        end
        return res;
    endfunction

endpackage

### design/gram_schmidt_orthonormalizer.sv
// ----------------------------------------------------------------------------
// gram_schmidt_orthonormalizer
// loads a q16.16 matrix column by column, removes projections onto earlier
// columns with one shared multiplier, normalizes and streams the result out
// ----------------------------------------------------------------------------
// channel   direction  handshake            payload
// element   in         i_valid / o_ready    i_element_value
// result    out        o_valid / i_ready    o_result_value, o_zero_norm,
//                                           o_saturated, o_last_result
// config    in         i_cfg_we             i_cfg_index, i_cfg_data
//
// one element transfer per cycle while loading; the last element starts the
// computation. each multiply-accumulate reads, multiplies on the single 32x32
// multiplier and accumulates; square root and division run bit-serially. each
// output element is read, registered and held until i_ready. synchronous reset,
// active low; a rows/cols/start write zeroes r_i/r_j but keeps the state.
// ----------------------------------------------------------------------------
module gram_schmidt_orthonormalizer #(
    parameter int MAX_ROWS = 8,
    parameter int MAX_COLS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_element_value,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_result_value,
    output logic        o_zero_norm,
    output logic        o_saturated,
    output logic        o_last_result,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [3:0]  i_cfg_data
);

    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

    typedef enum logic [4:0] {
        S_LOAD, S_COL,
        S_CF_RD, S_CF_MUL, S_CF_ACC, S_CF_WR,
        S_RS_RD0, S_RS_LD, S_RS_RD, S_RS_MUL, S_RS_ACC, S_RS_WR,
        S_NM_RD, S_NM_MUL, S_NM_ACC,
        S_SQ, S_ZW,
        S_DV_RD, S_DV_LD, S_DV_IT, S_DV_WR,
        S_OUT_RD, S_OUT_LD, S_OUT_WT
    } t_state;

    t_state             r_state;
    logic [3:0]         r_cfg_rows, r_cfg_cols, r_cfg_start;
    logic [3:0]         r_i, r_j, r_k;
    logic [33:0]        r_mem [DEPTH];
    logic signed [31:0] r_coef [MAX_COLS];
    logic [33:0]        r_rda, r_rdb;
    logic signed [31:0] r_rdc;
    logic signed [63:0] r_prod;
    logic signed [63:0] r_acc;
    logic               r_sat, r_csat, r_esat, r_neg;
    logic [63:0]        r_nsq, r_res, r_bit;
    logic [49:0]        r_rem;
    logic [17:0]        r_q;
    logic [4:0]         r_cnt;
    logic               r_out_valid;
    logic [31:0]        r_o_value;
    logic               r_o_zero, r_o_sat, r_o_last;

    logic [3:0]         w_rows, w_cols, w_start, w_rows_m1, w_cols_m1;
    logic [AW-1:0]      w_addra, w_addrb;
    logic               w_we;
    logic [33:0]        w_wdata;
    logic signed [31:0] w_opa, w_opb;
    gso_pkg::t_sat64    w_sadd;
    gso_pkg::t_sat32    w_rnd;
    logic [64:0]        w_nsq_sum;
    logic [63:0]        w_sq_trial;
    logic [32:0]        w_div;
    logic [49:0]        w_trial;
    logic [31:0]        w_qval;
    logic [31:0]        w_mag;
    logic               w_last;

    function automatic logic [AW-1:0] f_addr(logic [3:0] c, logic [3:0] r);
        return AW'(int'(c) * MAX_ROWS + int'(r));
    endfunction

    always_comb begin
        w_rows  = (r_cfg_rows == 4'd0) ? 4'd1 :
                  ((int'(r_cfg_rows) > MAX_ROWS) ? 4'(MAX_ROWS) : r_cfg_rows);
        w_cols  = (r_cfg_cols == 4'd0) ? 4'd1 :
                  ((int'(r_cfg_cols) > MAX_COLS) ? 4'(MAX_COLS) : r_cfg_cols);
        w_start = (r_cfg_start > w_cols) ? w_cols : r_cfg_start;
        w_rows_m1 = w_rows - 4'd1;
        w_cols_m1 = w_cols - 4'd1;
        w_addra = f_addr(r_k, r_i);
        w_addrb = f_addr(r_j, r_i);
        w_opa = (r_state == S_NM_MUL) ? r_rdb[31:0] : r_rda[31:0];
        w_opb = (r_state == S_RS_MUL) ? r_rdc : r_rdb[31:0];
        w_sadd = gso_pkg::sat_add64(r_acc, (r_state == S_RS_ACC) ? -r_prod : r_prod);
        w_rnd = gso_pkg::round_q16(r_acc);
        w_nsq_sum = {1'b0, r_nsq} + {1'b0, r_prod};
        w_sq_trial = r_res + r_bit;
        w_div = {r_res[31:0], 1'b0};
        w_trial = {17'd0, w_div} << r_cnt;
        w_qval = r_neg ? (32'd0 - {14'd0, r_q}) : {14'd0, r_q};
        w_mag = r_rdb[31] ? (32'd0 - r_rdb[31:0]) : r_rdb[31:0];
        w_last = (r_i == w_rows_m1) && (r_j == w_cols_m1);
        w_we = 1'b0;
        w_wdata = {2'b00, i_element_value};
        unique case (r_state)
            S_LOAD: begin
                w_we = i_valid;
            end
            S_RS_WR: begin
                w_we = 1'b1;
                w_wdata = {1'b0, r_sat | w_rnd.sat, w_rnd.val};
            end
            S_ZW: begin
                w_we = 1'b1;
                w_wdata = {2'b10, 32'd0};
            end
            S_DV_WR: begin
                w_we = 1'b1;
                w_wdata = {1'b0, r_csat | r_esat, w_qval};
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    assign o_ready        = (r_state == S_LOAD);
    assign o_valid        = r_out_valid;
    assign o_result_value = r_o_value;
    assign o_zero_norm    = r_o_zero;
    assign o_saturated    = r_o_sat;
    assign o_last_result  = r_o_last;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_addrb] <= w_wdata;
        end
        r_rda <= r_mem[w_addra];
        r_rdb <= r_mem[w_addrb];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_CF_WR) begin
            r_coef[CW'(r_k)] <= w_rnd.val;
        end
        r_rdc <= r_coef[CW'(r_k)];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_cfg_rows  <= 4'd8;
            r_cfg_cols  <= 4'd8;
            r_cfg_start <= 4'd0;
            r_i         <= 4'd0;
            r_j         <= 4'd0;
            r_k         <= 4'd0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_LOAD: begin
                    if (i_valid) begin
                        if (r_i == w_rows_m1) begin
                            r_i <= 4'd0;
                            if (r_j == w_cols_m1) begin
                                r_j     <= w_start;
                                r_state <= S_COL;
                            end else begin
                                r_j <= r_j + 4'd1;
                            end
                        end else begin
                            r_i <= r_i + 4'd1;
                        end
                    end
                end
                S_COL: begin
                    r_i    <= 4'd0;
                    r_k    <= 4'd0;
                    r_acc  <= '0;
                    r_sat  <= 1'b0;
                    r_csat <= 1'b0;
                    if (r_j == w_cols) begin
                        r_j     <= 4'd0;
                        r_state <= S_OUT_RD;
                    end else if (r_j == 4'd0) begin
                        r_state <= S_RS_RD0;
                    end else begin
                        r_state <= S_CF_RD;
                    end
                end
                S_CF_RD:  r_state <= S_CF_MUL;
                S_CF_MUL: begin
                    r_prod  <= w_opa * w_opb;
                    r_state <= S_CF_ACC;
                end
                S_CF_ACC: begin
                    r_acc <= w_sadd.val;
                    r_sat <= r_sat | w_sadd.sat;
                    if (r_i == w_rows_m1) begin
                        r_state <= S_CF_WR;
                    end else begin
                        r_i     <= r_i + 4'd1;
                        r_state <= S_CF_RD;
                    end
                end
                S_CF_WR: begin
                    r_csat <= r_csat | r_sat | w_rnd.sat;
                    r_acc  <= '0;
                    r_sat  <= 1'b0;
                    r_i    <= 4'd0;
                    if (r_k == r_j - 4'd1) begin
                        r_k     <= 4'd0;
                        r_state <= S_RS_RD0;
                    end else begin
                        r_k     <= r_k + 4'd1;
                        r_state <= S_CF_RD;
                    end
                end
                S_RS_RD0: r_state <= S_RS_LD;
                S_RS_LD: begin
                    r_acc <= {{16{r_rdb[31]}}, r_rdb[31:0], 16'd0};
                    r_sat <= 1'b0;
                    r_k   <= 4'd0;
                    r_state <= (r_j == 4'd0) ? S_RS_WR : S_RS_RD;
                end
                S_RS_RD:  r_state <= S_RS_MUL;
                S_RS_MUL: begin
                    r_prod  <= w_opa * w_opb;
                    r_state <= S_RS_ACC;
                end
                S_RS_ACC: begin
                    r_acc <= w_sadd.val;
                    r_sat <= r_sat | w_sadd.sat;
                    if (r_k == r_j - 4'd1) begin
                        r_state <= S_RS_WR;
                    end else begin
                        r_k     <= r_k + 4'd1;
                        r_state <= S_RS_RD;
                    end
                end
                S_RS_WR: begin
                    if (r_i == w_rows_m1) begin
                        r_i     <= 4'd0;
                        r_nsq   <= '0;
                        r_state <= S_NM_RD;
                    end else begin
                        r_i     <= r_i + 4'd1;
                        r_state <= S_RS_RD0;
                    end
                end
                S_NM_RD:  r_state <= S_NM_MUL;
                S_NM_MUL: begin
                    r_prod  <= w_opa * w_opb;
                    r_state <= S_NM_ACC;
                end
                S_NM_ACC: begin
                    r_nsq <= w_nsq_sum[64] ? {64{1'b1}} : w_nsq_sum[63:0];
                    if (r_i == w_rows_m1) begin
                        r_i     <= 4'd0;
                        r_res   <= '0;
                        r_bit   <= 64'd1 << 62;
                        r_state <= S_SQ;
                    end else begin
                        r_i     <= r_i + 4'd1;
                        r_state <= S_NM_RD;
                    end
                end
                S_SQ: begin
                    if (r_bit == 64'd0) begin
                        r_state <= (r_res == 64'd0) ? S_ZW : S_DV_RD;
                    end else begin
                        if (r_nsq >= w_sq_trial) begin
                            r_nsq <= r_nsq - w_sq_trial;
                            r_res <= (r_res >> 1) + r_bit;
                        end else begin
                            r_res <= r_res >> 1;
                        end
                        r_bit <= r_bit >> 2;
                    end
                end
                S_ZW: begin
                    if (r_i == w_rows_m1) begin
                        r_j     <= r_j + 4'd1;
                        r_state <= S_COL;
                    end else begin
                        r_i <= r_i + 4'd1;
                    end
                end
                S_DV_RD:  r_state <= S_DV_LD;
                S_DV_LD: begin
                    r_rem   <= {1'b0, w_mag, 17'd0} + {18'd0, r_res[31:0]};
                    r_q     <= '0;
                    r_cnt   <= 5'd17;
                    r_neg   <= r_rdb[31];
                    r_esat  <= r_rdb[32];
                    r_state <= S_DV_IT;
                end
                S_DV_IT: begin
                    if (r_rem >= w_trial) begin
                        r_rem <= r_rem - w_trial;
                        r_q   <= r_q | (18'd1 << r_cnt);
                    end
                    if (r_cnt == 5'd0) begin
                        r_state <= S_DV_WR;
                    end else begin
                        r_cnt <= r_cnt - 5'd1;
                    end
                end
                S_DV_WR: begin
                    if (r_i == w_rows_m1) begin
                        r_j     <= r_j + 4'd1;
                        r_state <= S_COL;
                    end else begin
                        r_i     <= r_i + 4'd1;
                        r_state <= S_DV_RD;
                    end
                end
                S_OUT_RD: r_state <= S_OUT_LD;
                S_OUT_LD: begin
                    r_o_value   <= r_rdb[31:0];
                    r_o_zero    <= r_rdb[33];
                    r_o_sat     <= r_rdb[32];
                    r_o_last    <= w_last;
                    r_out_valid <= 1'b1;
                    r_state     <= S_OUT_WT;
                end
                S_OUT_WT: begin
                    if (i_ready) begin
                        r_out_valid <= 1'b0;
                        if (w_last) begin
                            r_i     <= 4'd0;
                            r_j     <= 4'd0;
                            r_state <= S_LOAD;
                        end else begin
                            if (r_i == w_rows_m1) begin
                                r_i <= 4'd0;
                                r_j <= r_j + 4'd1;
                            end else begin
                                r_i <= r_i + 4'd1;
                            end
                            r_state <= S_OUT_RD;
                        end
                    end
                end
                default: r_state <= S_LOAD;
            endcase

            // a rows, cols or start write zeroes r_i and r_j but does not force S_LOAD
            if (i_cfg_we) begin
                priority if (i_cfg_index == gso_pkg::CFG_ROWS) begin
                    r_cfg_rows <= i_cfg_data;
                    r_i <= 4'd0;
                    r_j <= 4'd0;
                end else if (i_cfg_index == gso_pkg::CFG_COLS) begin
                    r_cfg_cols <= i_cfg_data;
                    r_i <= 4'd0;
                    r_j <= 4'd0;
                end else if (i_cfg_index == gso_pkg::CFG_START) begin
                    r_cfg_start <= i_cfg_data;
                    r_i <= 4'd0;
                    r_j <= 4'd0;
                end else begin
                    r_cfg_start <= r_cfg_start;
                end
            end
        end
    end

endmodule
